// File: sv/tsdc_pkg.sv
// Shared types, widths and arithmetic helpers for the triangle skew direction correction block.
// Depends on nothing; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tsdc_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 14;
    localparam int W_SENSE   = 2;
    localparam int W_VAL     = 16;
    localparam int W_CFG     = 15;
    localparam int W_IDX     = 1;

    // Widths along the imbalance path (each rounding removes FRAC_BITS bits)
    localparam int W_DIFF = W_VAL + 1;
    localparam int W_P1   = W_DIFF + W_CFG + 1;
    localparam int W_D    = W_P1 - FRAC_BITS + 1;
    localparam int W_SUM  = W_D + 1;
    localparam int W_Q    = W_SUM + W_CFG + 1;
    localparam int W_DEL  = W_Q - FRAC_BITS + 1;
    localparam int W_E    = W_D + W_CFG + 1;
    localparam int W_T    = W_E - FRAC_BITS + 1;
    localparam int W_G    = W_DEL + W_CFG + 1;
    localparam int W_DR   = W_G - FRAC_BITS + 1;
    localparam int W_RND  = W_G;

    // Widths along the square root and rotation path
    localparam int W_C    = FRAC_BITS + 2;
    localparam int W_SQ   = 2 * W_C;
    localparam int W_X    = 2 * FRAC_BITS + 1;
    localparam int W_RT   = W_X + 1;
    localparam int W_ROOT = FRAC_BITS + 1;
    localparam int N_ITER = FRAC_BITS + 1;
    localparam int W_PR   = W_VAL + W_C;
    localparam int W_PS   = W_PR + 1;

    // Stream widths
    localparam int W_TDATA_IN  = 104;
    localparam int W_TDATA_OUT = 32;

    // Constants
    localparam logic signed [W_RND-1:0] ONE_R     = W_RND'(1) << FRAC_BITS;
    localparam logic        [W_RND-1:0] HALF_R    = W_RND'(1) << (FRAC_BITS - 1);
    localparam logic signed [W_RND-1:0] VAL_MAX_R = W_RND'((2 ** (W_VAL - 1)) - 1);
    localparam logic signed [W_RND-1:0] VAL_MIN_R = -VAL_MAX_R - W_RND'(1);
    localparam logic        [W_X-1:0]   ONE_SQ    = W_X'(1) << (2 * FRAC_BITS);
    localparam logic        [W_ROOT-1:0] ONE_ROOT = W_ROOT'(1) << FRAC_BITS;

    // Configuration register indexes and reset values
    localparam logic [W_IDX-1:0] REG_DAMP_FACTOR = 1'b0;
    localparam logic [W_IDX-1:0] REG_DEAD_BAND   = 1'b1;
    localparam logic [W_CFG-1:0] DAMP_RESET      = 15'd11469;
    localparam logic [W_CFG-1:0] BAND_RESET      = 15'd164;

    // One input item as unpacked from the stream
    typedef struct packed {
        logic [W_SENSE-1:0]      sense;
        logic signed [W_VAL-1:0] a1;
        logic signed [W_VAL-1:0] b1;
        logic signed [W_VAL-1:0] a2;
        logic signed [W_VAL-1:0] b2;
        logic signed [W_VAL-1:0] ci;
        logic signed [W_VAL-1:0] si;
    } t_in;

    // Decoded sense and the direction riding along the imbalance stages
    typedef struct packed {
        logic                    neg;
        logic                    zero;
        logic signed [W_VAL-1:0] ci;
        logic signed [W_VAL-1:0] si;
    } t_meta;

    // Decision, clamped sine and direction
    typedef struct packed {
        logic                    pass;
        logic signed [W_C-1:0]   dsel;
        logic signed [W_VAL-1:0] ci;
        logic signed [W_VAL-1:0] si;
    } t_dir;

    // Front end to square root: decision plus the square of the sine
    typedef struct packed {
        t_dir           dir;
        logic [W_X-1:0] sq;
    } t_sq_item;

    // Square root to rotation: decision plus the cosine
    typedef struct packed {
        t_dir              dir;
        logic [W_ROOT-1:0] cdel;
    } t_root_item;

    // One result item
    typedef struct packed {
        logic                    corrected;
        logic signed [W_VAL-1:0] sin_v;
        logic signed [W_VAL-1:0] cos_v;
    } t_res;

    // Round a product back to FRAC_BITS fraction bits, ties away from zero
    function automatic logic signed [W_RND-1:0] rnd_q(input logic signed [W_RND-1:0] x);
        logic [W_RND-1:0] mag;
        logic [W_RND-1:0] q;
        mag = x[W_RND-1] ? $unsigned(-x) : $unsigned(x);
        q = (mag + HALF_R) >> FRAC_BITS;
        rnd_q = x[W_RND-1] ? -$signed(q) : $signed(q);
    endfunction

    // Multiply by the rotation sense (-1, 0 or +1)
    function automatic logic signed [W_RND-1:0] apply_sense(
        input logic                    neg,
        input logic                    zero,
        input logic signed [W_RND-1:0] x
    );
        if (zero) begin
            apply_sense = '0;
        end else if (neg) begin
            apply_sense = -x;
        end else begin
            apply_sense = x;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/triangle_skew_direction_correction.sv
// Results run through the front, square root and rotation stages into the output buffer.
// Throughput: one transaction per cycle; the pipeline takes a new item every cycle unless
// two finished results wait at the output, the square root costing one stage per root bit.
// Reset (i_rst_n low, synchronous) empties the pipeline and the output buffer and loads
// damp_factor with 0.7 and dead_band with 0.01.
// Top level: stream ports, configuration registers, output buffer; uses tsdc_pkg and submodules.
`timescale 1ns / 1ps
`default_nettype none

module triangle_skew_direction_correction (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // rotation_sense[1:0], first_sin_a[17:2], first_sin_b[33:18], second_sin_a[49:34],
    // second_sin_b[65:50], dir_cos_in[81:66], dir_sin_in[97:82], zero pad[103:98]
    input  logic [tsdc_pkg::W_TDATA_IN-1:0]   i_s_tdata,
    // Output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // dir_cos_out[15:0], dir_sin_out[31:16]
    output logic [tsdc_pkg::W_TDATA_OUT-1:0]  o_m_tdata,
    // corrected[0]
    output logic [0:0]                        o_m_tuser,
    // Configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [tsdc_pkg::W_IDX-1:0]        i_cfg_index,
    input  logic [tsdc_pkg::W_CFG-1:0]        i_cfg_wdata
);
    import tsdc_pkg::*;

    logic [W_CFG-1:0] r_damp_factor;
    logic [W_CFG-1:0] r_dead_band;

    t_in        w_in;
    logic       w_adv;
    logic       w_front_valid;
    t_sq_item   w_front_item;
    logic       w_root_valid;
    t_root_item w_root_item;
    logic       w_res_valid;
    t_res       w_res;
    logic       w_push;
    logic       w_pop;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp_factor <= DAMP_RESET;
            r_dead_band   <= BAND_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DAMP_FACTOR: r_damp_factor <= i_cfg_wdata;
                REG_DEAD_BAND:   r_dead_band   <= i_cfg_wdata;
                default:         r_dead_band   <= r_dead_band;
            endcase
        end
    end

    // Unpack the input transaction
    assign w_in.sense = i_s_tdata[1:0];
    assign w_in.a1    = $signed(i_s_tdata[17:2]);
    assign w_in.b1    = $signed(i_s_tdata[33:18]);
    assign w_in.a2    = $signed(i_s_tdata[49:34]);
    assign w_in.b2    = $signed(i_s_tdata[65:50]);
    assign w_in.ci    = $signed(i_s_tdata[81:66]);
    assign w_in.si    = $signed(i_s_tdata[97:82]);

    // The whole pipeline advances unless the output buffer is full
    assign w_adv      = !r_skid_valid;
    assign o_s_tready = w_adv;

    tsdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (i_s_tvalid),
        .i_item        (w_in),
        .i_damp_factor (r_damp_factor),
        .i_dead_band   (r_dead_band),
        .o_valid       (w_front_valid),
        .o_item        (w_front_item)
    );

    tsdc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_front_valid),
        .i_item  (w_front_item),
        .o_valid (w_root_valid),
        .o_item  (w_root_item)
    );

    tsdc_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_root_valid),
        .i_item  (w_root_item),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    // Two-entry output buffer: output register plus skid register
    assign w_push = w_res_valid && w_adv;
    assign w_pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (r_out_valid) begin
                if (w_push && !w_pop) begin
                    r_skid_valid <= 1'b1;
                end else if (!w_push && w_pop) begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_push) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (r_out_valid) begin
            if (w_push && w_pop) begin
                r_out <= w_res;
            end else if (w_push) begin
                r_skid <= w_res;
            end
        end else if (w_push) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out.sin_v, r_out.cos_v};
    assign o_m_tuser[0] = r_out.corrected;

    // The skid register is only ever filled behind a held output register
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data while output register is empty");

    // The skid register fills only after a stalled output transaction
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid register filled without an output stall");

    // While the pipeline is held its last stage does not change
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_res_valid))
        else $error("pipeline moved while held");

endmodule

`default_nettype wire

// File: sv/tsdc_front.sv
// Imbalance pipeline: damped imbalance, dead band decision, clamp and square of the sine.
// Depends on tsdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsdc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  tsdc_pkg::t_in               i_item,
    input  logic [tsdc_pkg::W_CFG-1:0]  i_damp_factor,
    input  logic [tsdc_pkg::W_CFG-1:0]  i_dead_band,
    output logic                        o_valid,
    output tsdc_pkg::t_sq_item          o_item
);
    import tsdc_pkg::*;

    localparam int N_STAGE = 10;

    logic [N_STAGE-1:0] r_valid;

    logic signed [W_CFG:0] w_sf;

    // Stage registers
    t_meta                    r_a_meta, r_b_meta, r_c_meta, r_d_meta, r_e_meta;
    t_meta                    r_f_meta, r_g_meta, r_h_meta;
    logic signed [W_DIFF-1:0] r_a_da1, r_a_da2;
    logic signed [W_P1-1:0]   r_b_p1, r_b_p2;
    logic signed [W_D-1:0]    r_c_d1, r_c_d2, r_d_d1, r_d_d2, r_e_d1, r_e_d2;
    logic signed [W_D-1:0]    r_f_d1, r_f_d2, r_g_d1, r_g_d2, r_h_d1, r_h_d2;
    logic signed [W_SUM-1:0]  r_d_sum;
    logic signed [W_Q-1:0]    r_e_q;
    logic signed [W_E-1:0]    r_e_e1, r_e_e2;
    logic signed [W_DEL-1:0]  r_f_del, r_g_del, r_h_del;
    logic signed [W_T-1:0]    r_f_t1, r_f_t2, r_g_t1, r_g_t2, r_h_t1, r_h_t2;
    logic signed [W_G-1:0]    r_g_g;
    logic signed [W_DR-1:0]   r_h_deldr;
    t_dir                     r_i_dir;
    t_sq_item                 r_j_item;

    // Decision logic
    logic signed [W_RND-1:0] w_deldr;
    logic signed [W_RND-1:0] w_band;
    logic signed [W_RND-1:0] w_pick;
    logic signed [W_RND-1:0] w_clamp;
    logic                    w_pass;
    logic                    w_alt;

    assign w_sf = $signed({1'b0, i_damp_factor});

    // Valid bits move with the data whenever the pipeline advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N_STAGE-2:0], i_valid};
        end
    end

    // Dead band test and choice of the per-triangle term on the side of the imbalance
    assign w_deldr = W_RND'(r_h_deldr);
    assign w_band  = W_RND'($signed({1'b0, i_dead_band}));

    always_comb begin
        if (!w_deldr[W_RND-1]) begin
            w_pass = (w_deldr < w_band);
            w_alt  = (w_deldr > W_RND'(r_h_t2));
            w_pick = w_alt ? W_RND'(r_h_d2) : W_RND'(r_h_del);
        end else begin
            w_pass = (w_deldr > -w_band);
            w_alt  = (w_deldr < W_RND'(r_h_t1));
            w_pick = w_alt ? W_RND'(r_h_d1) : W_RND'(r_h_del);
        end
        if (w_pick > ONE_R) begin
            w_clamp = ONE_R;
        end else if (w_pick < -ONE_R) begin
            w_clamp = -ONE_R;
        end else begin
            w_clamp = w_pick;
        end
    end

    // Data path stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Sense decode and sine differences
            r_a_meta.neg  <= i_item.sense[W_SENSE-1];
            r_a_meta.zero <= (i_item.sense == '0);
            r_a_meta.ci   <= i_item.ci;
            r_a_meta.si   <= i_item.si;
            r_a_da1       <= W_DIFF'(i_item.a1) - W_DIFF'(i_item.b1);
            r_a_da2       <= W_DIFF'(i_item.a2) - W_DIFF'(i_item.b2);

            // Differences times the damping factor
            r_b_meta <= r_a_meta;
            r_b_p1   <= W_P1'(r_a_da1) * W_P1'(w_sf);
            r_b_p2   <= W_P1'(r_a_da2) * W_P1'(w_sf);

            // Per-triangle terms
            r_c_meta <= r_b_meta;
            r_c_d1   <= W_D'(apply_sense(r_b_meta.neg, r_b_meta.zero, rnd_q(W_RND'(r_b_p1))));
            r_c_d2   <= W_D'(apply_sense(r_b_meta.neg, r_b_meta.zero, rnd_q(W_RND'(r_b_p2))));

            // Sum of the two terms
            r_d_meta <= r_c_meta;
            r_d_sum  <= W_SUM'(r_c_d1) + W_SUM'(r_c_d2);
            r_d_d1   <= r_c_d1;
            r_d_d2   <= r_c_d2;

            // Damped sum and per-triangle terms times the factor
            r_e_meta <= r_d_meta;
            r_e_q    <= W_Q'(r_d_sum) * W_Q'(w_sf);
            r_e_e1   <= W_E'(r_d_d1) * W_E'(w_sf);
            r_e_e2   <= W_E'(r_d_d2) * W_E'(w_sf);
            r_e_d1   <= r_d_d1;
            r_e_d2   <= r_d_d2;

            // Imbalance and side limits
            r_f_meta <= r_e_meta;
            r_f_del  <= W_DEL'(rnd_q(W_RND'(r_e_q)));
            r_f_t1   <= W_T'(apply_sense(r_e_meta.neg, r_e_meta.zero, rnd_q(W_RND'(r_e_e1))));
            r_f_t2   <= W_T'(apply_sense(r_e_meta.neg, r_e_meta.zero, rnd_q(W_RND'(r_e_e2))));
            r_f_d1   <= r_e_d1;
            r_f_d2   <= r_e_d2;

            // Imbalance times the factor
            r_g_meta <= r_f_meta;
            r_g_g    <= W_G'(r_f_del) * W_G'(w_sf);
            r_g_del  <= r_f_del;
            r_g_t1   <= r_f_t1;
            r_g_t2   <= r_f_t2;
            r_g_d1   <= r_f_d1;
            r_g_d2   <= r_f_d2;

            // Imbalance seen along the sense
            r_h_meta  <= r_g_meta;
            r_h_deldr <= W_DR'(apply_sense(r_g_meta.neg, r_g_meta.zero, rnd_q(W_RND'(r_g_g))));
            r_h_del   <= r_g_del;
            r_h_t1    <= r_g_t1;
            r_h_t2    <= r_g_t2;
            r_h_d1    <= r_g_d1;
            r_h_d2    <= r_g_d2;

            // Decision and clamped sine
            r_i_dir.pass <= w_pass;
            r_i_dir.dsel <= W_C'(w_clamp);
            r_i_dir.ci   <= r_h_meta.ci;
            r_i_dir.si   <= r_h_meta.si;

            // Square of the sine
            r_j_item.dir <= r_i_dir;
            r_j_item.sq  <= W_X'($unsigned(W_SQ'(r_i_dir.dsel) * W_SQ'(r_i_dir.dsel)));
        end
    end

    assign o_valid = r_valid[N_STAGE-1];
    assign o_item  = r_j_item;

endmodule

`default_nettype wire

// File: sv/tsdc_sqrt.sv
// Pipelined square root of ONE^2 - del^2, one result bit per stage, rounded to nearest.
// Depends on tsdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsdc_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  tsdc_pkg::t_sq_item    i_item,
    output logic                  o_valid,
    output tsdc_pkg::t_root_item  o_item
);
    import tsdc_pkg::*;

    logic [N_ITER+1:0] r_valid;
    logic [W_X-1:0]    r_rem  [0:N_ITER];
    logic [W_RT-1:0]   r_root [0:N_ITER];
    t_dir              r_dir  [0:N_ITER];
    t_root_item        r_out;
    logic              w_inc;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N_ITER:0], i_valid};
        end
    end

    // Radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= ONE_SQ - i_item.sq;
            r_root[0] <= '0;
            r_dir[0]  <= i_item.dir;
        end
    end

    // Digit-by-digit square root, one root bit per stage
    for (genvar k = 0; k < N_ITER; k++) begin : g_iter
        localparam logic [W_RT-1:0] BIT = W_RT'(1) << (2 * (FRAC_BITS - k));
        logic [W_RT-1:0] w_trial;
        logic            w_take;

        assign w_trial = r_root[k] + BIT;
        assign w_take  = (W_RT'(r_rem[k]) >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_take ? (r_rem[k] - W_X'(w_trial)) : r_rem[k];
                r_root[k+1] <= w_take ? ((r_root[k] >> 1) + BIT) : (r_root[k] >> 1);
                r_dir[k+1]  <= r_dir[k];
            end
        end
    end

    // Round up when the remainder exceeds the floor root
    assign w_inc = (W_RT'(r_rem[N_ITER]) > r_root[N_ITER]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.dir  <= r_dir[N_ITER];
            r_out.cdel <= W_ROOT'(r_root[N_ITER]) + W_ROOT'(w_inc);
        end
    end

    assign o_valid = r_valid[N_ITER+1];
    assign o_item  = r_out;

    // The cosine never exceeds one
    a_cdel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.cdel <= ONE_ROOT))
        else $error("square root result above one");

    // A zero sine gives a cosine of exactly one
    a_cdel_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.dir.dsel == '0)) |-> (o_item.cdel == ONE_ROOT))
        else $error("zero sine did not give unit cosine");

endmodule

`default_nettype wire

// File: sv/tsdc_rotate.sv
// Rotation of the direction by (cdel, del), rounding, saturation and dead band bypass.
// Depends on tsdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsdc_rotate (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  tsdc_pkg::t_root_item  i_item,
    output logic                  o_valid,
    output tsdc_pkg::t_res        o_res
);
    import tsdc_pkg::*;

    logic [1:0]             r_valid;
    logic signed [W_C-1:0]  w_cdel_s;
    logic signed [W_PR-1:0] r_a_pa, r_a_pb, r_a_pc, r_a_pd;
    logic signed [W_PS-1:0] r_b_sc, r_b_ss;
    t_dir                   r_a_dir, r_b_dir;

    // Clamp to [-ONE, ONE] and then to the signed output range
    function automatic logic signed [W_VAL-1:0] clamp_out(input logic signed [W_RND-1:0] x);
        logic signed [W_RND-1:0] y;
        if (x > ONE_R) begin
            y = ONE_R;
        end else if (x < -ONE_R) begin
            y = -ONE_R;
        end else begin
            y = x;
        end
        if (y > VAL_MAX_R) begin
            y = VAL_MAX_R;
        end else if (y < VAL_MIN_R) begin
            y = VAL_MIN_R;
        end
        clamp_out = W_VAL'(y);
    endfunction

    assign w_cdel_s = $signed({1'b0, i_item.cdel});

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[0], i_valid};
        end
    end

    // Products, then the rotated sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dir <= i_item.dir;
            r_a_pa  <= W_PR'(i_item.dir.ci) * W_PR'(w_cdel_s);
            r_a_pb  <= W_PR'(i_item.dir.si) * W_PR'(i_item.dir.dsel);
            r_a_pc  <= W_PR'(i_item.dir.ci) * W_PR'(i_item.dir.dsel);
            r_a_pd  <= W_PR'(i_item.dir.si) * W_PR'(w_cdel_s);

            r_b_dir <= r_a_dir;
            r_b_sc  <= W_PS'(r_a_pa) - W_PS'(r_a_pb);
            r_b_ss  <= W_PS'(r_a_pc) + W_PS'(r_a_pd);
        end
    end

    // Inside the dead band the direction passes unchanged
    always_comb begin
        if (r_b_dir.pass) begin
            o_res.cos_v     = r_b_dir.ci;
            o_res.sin_v     = r_b_dir.si;
            o_res.corrected = 1'b0;
        end else begin
            o_res.cos_v     = clamp_out(rnd_q(W_RND'(r_b_sc)));
            o_res.sin_v     = clamp_out(rnd_q(W_RND'(r_b_ss)));
            o_res.corrected = 1'b1;
        end
    end

    assign o_valid = r_valid[1];

endmodule

`default_nettype wire

// File: test/triangle_skew_direction_correction_test.sv
// Self-checking testbench for the triangle skew direction correction block.
// Drives the stream ports with random idle bursts; checks each result by predictor or table row.
// Depends on tsdc_pkg and triangle_skew_direction_correction.
`timescale 1ns / 1ps

module triangle_skew_direction_correction_test;
    import tsdc_pkg::*;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     N_PHASES      = 9;
    localparam int     PHASE_ITEMS   = 185;
    localparam int     N_DIRECTED    = 24;
    localparam int     RANDOM_CFG    = -1;
    localparam longint Q_ONE         = 64'sd1 <<< FRAC_BITS;

    // Rotation sense encodings on the 2-bit field
    localparam logic [W_SENSE-1:0] SENSE_ZERO = 2'b00;
    localparam logic [W_SENSE-1:0] SENSE_POS  = 2'b01;
    localparam logic [W_SENSE-1:0] SENSE_NEG2 = 2'b10;
    localparam logic [W_SENSE-1:0] SENSE_NEG  = 2'b11;

    localparam logic signed [W_VAL-1:0] P1 = 16'sd16384;
    localparam logic signed [W_VAL-1:0] M1 = -16'sd16384;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One row of the directed table: either a register write or an item,
    // the latter with an optional hand-written expectation.
    typedef struct packed {
        t_row_kind        kind;
        logic [W_IDX-1:0] reg_idx;
        logic [W_CFG-1:0] reg_val;
        t_in              item;
        logic             typed;
        t_res             known;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [W_TDATA_IN-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic [W_TDATA_OUT-1:0] o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   i_cfg_wr_en = 1'b0;
    logic [W_IDX-1:0]       i_cfg_index = '0;
    logic [W_CFG-1:0]       i_cfg_wdata = '0;

    t_res             expected_dirs [$];
    logic [W_CFG-1:0] damp_now = DAMP_RESET;
    logic [W_CFG-1:0] band_now = BAND_RESET;
    bit               bursts_on = 1'b1;
    int               failures = 0;
    int               cycle_count = 0;

    // Directed rows: the defaults first, then unit damping with no dead band,
    // then zero damping, then the widest dead band.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_ZERO, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b1, '{1'b0, 16'sd0, 16'sd0}},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_ZERO, P1, M1, M1, P1, P1, M1}, 1'b1, '{1'b0, M1, P1}},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_ZERO, M1, P1, P1, M1, M1, P1}, 1'b1, '{1'b0, P1, M1}},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, P1, M1, P1, M1, P1, 16'sd0}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG, P1, M1, P1, M1, 16'sd0, P1}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG2, P1, M1, P1, M1, 16'sd0, P1}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, M1, P1, M1, P1, P1, 16'sd0}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, 16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, -16'sd2000}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG, 16'sd0, 16'sd12, 16'sd0, 16'sd0, -16'sd3000, 16'sd500}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, P1, 16'sd0, 16'sd0, P1, 16'sd11585, -16'sd11585}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, 16'sd0, M1, 16'sd8000, 16'sd0, M1, M1}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG, 16'sd3000, 16'sd1000, -16'sd2000, 16'sd500, 16'sd11585, 16'sd11585},
          1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, 16'sd4000, 16'sd0, 16'sd4000, 16'sd0, P1, P1}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG, 16'sd4000, 16'sd0, 16'sd4000, 16'sd0, M1, M1}, 1'b0, '0},
        '{ROW_CFG, REG_DAMP_FACTOR, 15'd16384, '0, 1'b0, '0},
        '{ROW_CFG, REG_DEAD_BAND, 15'd0, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_ZERO, P1, P1, M1, M1, P1, M1}, 1'b1, '{1'b1, M1, P1}},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_ZERO, 16'sd100, -16'sd100, 16'sd7, 16'sd9, -16'sd5, 16'sd7},
          1'b1, '{1'b1, 16'sd7, -16'sd5}},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, P1, M1, P1, M1, 16'sd0, P1}, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG2, M1, P1, 16'sd0, 16'sd0, P1, 16'sd0}, 1'b0, '0},
        '{ROW_CFG, REG_DAMP_FACTOR, 15'd0, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_POS, P1, M1, M1, P1, 16'sd1234, -16'sd4321}, 1'b0, '0},
        '{ROW_CFG, REG_DEAD_BAND, 15'd16384, '0, 1'b0, '0},
        '{ROW_ITEM, REG_DAMP_FACTOR, 15'd0,
          '{SENSE_NEG, P1, M1, P1, M1, P1, P1}, 1'b0, '0}
    };

    // Register settings of the random phases; the last one runs without idling.
    int phase_damp [N_PHASES] = '{11469, 0, 16384, 16384, 0,
                                  RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, 11469};
    int phase_band [N_PHASES] = '{164, 0, 16384, 0, 16384,
                                  RANDOM_CFG, RANDOM_CFG, RANDOM_CFG, 164};

    triangle_skew_direction_correction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // Round a product with 2*FRAC_BITS fraction bits to nearest, ties away from zero.
    function automatic longint round_q(input longint x);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_unit(input longint x);
        return (x < -Q_ONE) ? -Q_ONE : ((x > Q_ONE) ? Q_ONE : x);
    endfunction

    // Integer square root rounded to nearest.
    function automatic longint nearest_root(input longint x);
        longint r;
        r = longint'($rtoi($sqrt(real'(x))));
        while (r * r > x) r--;
        while ((r + 1) * (r + 1) <= x) r++;
        if (x - r * r > r) r++;
        return r;
    endfunction

    // Expected new direction for one item under the given register values.
    function automatic t_res predict_direction(input t_in it, input logic [W_CFG-1:0] f_reg,
                                               input logic [W_CFG-1:0] band_reg);
        longint sense, f, band, dr, d1, d2, del, deldr, cdel, co, so;
        t_res   res;
        sense = ($signed(it.sense) > 0) ? 1 : (($signed(it.sense) < 0) ? -1 : 0);
        f     = longint'(f_reg);
        band  = longint'(band_reg);
        dr    = sense * f;
        d1    = round_q((longint'(it.a1) - longint'(it.b1)) * dr);
        d2    = round_q((longint'(it.a2) - longint'(it.b2)) * dr);
        del   = round_q((d1 + d2) * f);
        deldr = round_q(del * dr);
        res.cos_v     = it.ci;
        res.sin_v     = it.si;
        res.corrected = 1'b0;
        // Inside the dead band the direction passes through; otherwise, past the side
        // limit, the sine is pulled back to the per-triangle term on its own side.
        if (deldr >= 0) begin
            if (deldr < band) return res;
            if (deldr > round_q(d2 * dr)) del = d2;
        end else begin
            if (deldr > -band) return res;
            if (deldr < round_q(d1 * dr)) del = d1;
        end
        del  = clamp_unit(del);
        cdel = nearest_root(Q_ONE * Q_ONE - del * del);
        co   = clamp_unit(round_q(longint'(it.ci) * cdel - longint'(it.si) * del));
        so   = clamp_unit(round_q(longint'(it.ci) * del + longint'(it.si) * cdel));
        res.cos_v     = W_VAL'(co);
        res.sin_v     = W_VAL'(so);
        res.corrected = 1'b1;
        return res;
    endfunction

    // Mostly in the unit range, with extremes and now and then the full 16-bit range.
    function automatic logic signed [W_VAL-1:0] random_sine();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            v = $urandom_range(0, 65535);
        end else if (pick < 14) begin
            v = (pick < 8) ? -16384 : ((pick < 12) ? 16384 : 0);
        end else begin
            v = $urandom_range(0, 32768);
            v = v - 16384;
        end
        return W_VAL'(v);
    endfunction

    // A sine close to another one, so that the imbalance lands near the dead band.
    function automatic logic signed [W_VAL-1:0] nearby_sine(input logic signed [W_VAL-1:0] base);
        int v;
        v = $urandom_range(0, 600);
        v = int'(base) + v - 300;
        v = (v < -16384) ? -16384 : ((v > 16384) ? 16384 : v);
        return W_VAL'(v);
    endfunction

    function automatic t_in random_triangle_pair();
        t_in it;
        it.sense = W_SENSE'($urandom_range(0, 3));
        it.a1    = random_sine();
        it.a2    = random_sine();
        if ($urandom_range(0, 9) < 4) begin
            it.b1 = nearby_sine(it.a1);
            it.b2 = nearby_sine(it.a2);
        end else begin
            it.b1 = random_sine();
            it.b2 = random_sine();
        end
        it.ci = random_sine();
        it.si = random_sine();
        return it;
    endfunction

    // Offer one item, possibly after an idle burst, and record its expectation
    // at the edge that accepts the transaction.
    task automatic push_item(input t_in it, input logic typed, input t_res known);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, it.si, it.ci, it.b2, it.a2, it.b1, it.a1, it.sense};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_dirs.push_back(typed ? known : predict_direction(it, damp_now, band_now));
    endtask

    // Hold the input stream idle until every expected result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_dirs.size() != 0);
    endtask

    task automatic write_register(input logic [W_IDX-1:0] idx, input logic [W_CFG-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_DAMP_FACTOR: damp_now = val;
            REG_DEAD_BAND:   band_now = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Output side: check each accepted transaction, then pick the next tready.
    initial begin : result_monitor
        t_res got;
        t_res want;
        int   stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
                got.cos_v     = o_m_tdata[15:0];
                got.sin_v     = o_m_tdata[31:16];
                got.corrected = o_m_tuser[0];
                if (expected_dirs.size() == 0) begin
                    $error("unexpected result: dir_cos_out=%0d dir_sin_out=%0d corrected=%0b",
                           got.cos_v, got.sin_v, got.corrected);
                    failures++;
                end else begin
                    want = expected_dirs.pop_front();
                    if (got.cos_v !== want.cos_v) begin
                        $error("dir_cos_out: expected %0d, got %0d", want.cos_v, got.cos_v);
                        failures++;
                    end
                    if (got.sin_v !== want.sin_v) begin
                        $error("dir_sin_out: expected %0d, got %0d", want.sin_v, got.sin_v);
                        failures++;
                    end
                    if (got.corrected !== want.corrected) begin
                        $error("corrected: expected %0b, got %0b", want.corrected, got.corrected);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_stim_row row;
        t_res      none;
        int        damp_val;
        int        band_val;
        none = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; register writes wait for the pipeline to empty.
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_register(row.reg_idx, row.reg_val);
            end else begin
                push_item(row.item, row.typed, row.known);
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            damp_val = (phase_damp[p] == RANDOM_CFG) ? $urandom_range(0, 16384) : phase_damp[p];
            band_val = (phase_band[p] == RANDOM_CFG) ? $urandom_range(0, 2000) : phase_band[p];
            write_register(REG_DAMP_FACTOR, W_CFG'(damp_val));
            write_register(REG_DEAD_BAND, W_CFG'(band_val));
            bursts_on = (p != N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through one phase the sender waits for the pipeline to empty.
                if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
                push_item(random_triangle_pair(), 1'b0, none);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_dirs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
